// ----- hw/rtl/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the scaled decimal adder: transfer structs,
// configuration register indexes, pipeline payload and the power-of-ten table.
// ----------------------------------------------------------------------------
package dsa_pkg;

  // configuration register width and index codes
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_PREC   = 2'd0,
    CFG_LEFT_SCALE  = 2'd1,
    CFG_RIGHT_PREC  = 2'd2,
    CFG_RIGHT_SCALE = 2'd3
  } cfg_idx_t;

  // reset values of the type registers
  localparam logic [CFG_W-1:0] LEFT_PREC_RST   = 7'd38;
  localparam logic [CFG_W-1:0] LEFT_SCALE_RST  = 7'd0;
  localparam logic [CFG_W-1:0] RIGHT_PREC_RST  = 7'd38;
  localparam logic [CFG_W-1:0] RIGHT_SCALE_RST = 7'd0;

  // value widths
  localparam int WORD_W = 64;
  localparam int VAL_W  = 4 * WORD_W;

  // result precision is capped at this many digits
  localparam int MAX_RESULT_PREC = 65;
  localparam int PREC_W          = $clog2(MAX_RESULT_PREC + 1);

  // one x5 stage for the odd digit, then one x25 stage per pair of digits
  localparam int SCALE_STAGES = 2 ** (CFG_W - 1);

  typedef struct packed {
    logic [WORD_W-1:0] left_word0;
    logic [WORD_W-1:0] left_word1;
    logic [WORD_W-1:0] left_word2;
    logic [WORD_W-1:0] left_word3;
    logic              left_is_null;
    logic [WORD_W-1:0] right_word0;
    logic [WORD_W-1:0] right_word1;
    logic [WORD_W-1:0] right_word2;
    logic [WORD_W-1:0] right_word3;
    logic              right_is_null;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum_word0;
    logic [WORD_W-1:0] sum_word1;
    logic [WORD_W-1:0] sum_word2;
    logic [WORD_W-1:0] sum_word3;
    logic              sum_is_null;
    logic              overflow;
  } out_item_t;

  // payload carried through the scaling pipeline
  typedef struct packed {
    logic [VAL_W-1:0]  scaled;
    logic [VAL_W-1:0]  addend;
    logic              is_null;
    logic [CFG_W-1:0]  scale_exp;
    logic [PREC_W-1:0] prec;
  } scale_pipe_t;

  // powers of ten up to the precision cap, built at elaboration
  typedef logic [MAX_RESULT_PREC:0][VAL_W-1:0] pow10_tab_t;

  function automatic pow10_tab_t pow10_table();
    pow10_tab_t       tab;
    logic [VAL_W-1:0] p;
    p = VAL_W'(1);
    for (int k = 0; k <= MAX_RESULT_PREC; k++) begin
      tab[k] = p;
      p = (p << 3) + (p << 1);
    end
    return tab;
  endfunction

  localparam pow10_tab_t POW10 = pow10_table();

endpackage

// ----- hw/rtl/dsa_scaler.sv -----
// ----------------------------------------------------------------------------
// dsa_scaler
// Multiplies the scaled operand by five to the power of its scale difference,
// one x5 stage for the odd digit and a chain of x25 stages, one per register.
// The matching power of two is applied downstream as a shift.
// ----------------------------------------------------------------------------
module dsa_scaler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  dsa_pkg::scale_pipe_t in_pipe,
  output logic                out_vld,
  output dsa_pkg::scale_pipe_t out_pipe
);

  import dsa_pkg::*;

  localparam int HALF_W = CFG_W - 1;

  scale_pipe_t             stage_r   [SCALE_STAGES];
  scale_pipe_t             stage_nxt [SCALE_STAGES];
  logic [SCALE_STAGES-1:0] vld_r;

  function automatic logic [VAL_W-1:0] times5(input logic [VAL_W-1:0] x);
    return x + (x << 2);
  endfunction

  function automatic logic [VAL_W-1:0] times25(input logic [VAL_W-1:0] x);
    return x + (x << 3) + (x << 4);
  endfunction

  function automatic scale_pipe_t apply_mul(input scale_pipe_t p, input logic en,
                                            input logic by25);
    scale_pipe_t r;
    r = p;
    if (en) begin
      r.scaled = by25 ? times25(p.scaled) : times5(p.scaled);
    end
    return r;
  endfunction

  // per-stage multiply: first stage takes the odd factor, the rest a pair each
  for (genvar k = 0; k < SCALE_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign stage_nxt[k] = apply_mul(in_pipe, in_pipe.scale_exp[0], 1'b0);
    end else begin : g_pair
      assign stage_nxt[k] = apply_mul(stage_r[k-1],
        (HALF_W'(k - 1) < stage_r[k-1].scale_exp[CFG_W-1:1]), 1'b1);
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < SCALE_STAGES; k++) begin
      stage_r[k] <= stage_nxt[k];
    end
  end

  // valid bits travel with the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SCALE_STAGES-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[SCALE_STAGES-1];
  assign out_pipe = stage_r[SCALE_STAGES-1];

endmodule

// ----- hw/rtl/decimal_scaled_add_top.sv -----
// ----------------------------------------------------------------------------
// decimal_scaled_add_top
// Adds two 256-bit unscaled SQL decimals after aligning their scales, and
// flags rows whose sum needs more digits than the derived result precision.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; a row transfers at every rising edge
//   with start high and busy low. busy stays low, so a row can enter on every
//   cycle.
//   Output: each result sits on out_data for one cycle with out_valid high and
//   transfers at the edge that ends it; the receiver cannot hold it off, and
//   results leave in the order the rows came in.
//   Configuration: cfg_we writes cfg_wdata into the type register chosen by
//   cfg_index at the same edge; write only while no row is in flight.
//   Pipeline: a row passes one entry stage, a 64-stage chain of x5/x25
//   multipliers for the power of ten, then shift, add, magnitude and compare
//   stages before out_valid rises.
//   Throughput: one row per cycle.
//   Reset: synchronous, active low; clears all valid bits so nothing in flight
//   is delivered, and returns the type registers to 38/0/38/0.
// ----------------------------------------------------------------------------
module decimal_scaled_add_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  dsa_pkg::in_item_t                in_data,
  output logic                             out_valid,
  output dsa_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsa_pkg::CFG_W-1:0]        cfg_wdata
);

  import dsa_pkg::*;

  localparam int DIFF_W = CFG_W + 2;
  localparam int SUMP_W = CFG_W + 3;

  // type registers
  logic [CFG_W-1:0] left_prec_r, left_scale_r, right_prec_r, right_scale_r;

  // entry stage
  logic                    entry_vld_r;
  scale_pipe_t             entry_r, entry_nxt;
  logic                    left_smaller;
  logic [CFG_W-1:0]        res_scale;
  logic signed [DIFF_W-1:0] left_int, right_int, res_int;
  logic signed [SUMP_W-1:0] res_prec_full;

  // scaler output
  logic                    scl_vld;
  scale_pipe_t             scl_pipe;

  // shift stage
  logic                    sh_vld_r;
  logic [VAL_W-1:0]        sh_scaled_r, sh_addend_r, sh_limit_r;
  logic                    sh_null_r;

  // add stage
  logic                    add_vld_r;
  logic [VAL_W-1:0]        add_sum_r, add_limit_r;
  logic                    add_null_r;

  // magnitude stage
  logic                    mag_vld_r;
  logic [VAL_W-1:0]        mag_sum_r, mag_abs_r, mag_limit_r;
  logic                    mag_null_r;

  // output stage
  logic                    out_vld_r;
  out_item_t               out_r, out_nxt;
  logic                    over;

  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_prec_r   <= LEFT_PREC_RST;
      left_scale_r  <= LEFT_SCALE_RST;
      right_prec_r  <= RIGHT_PREC_RST;
      right_scale_r <= RIGHT_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEFT_PREC:   left_prec_r   <= cfg_wdata;
        CFG_LEFT_SCALE:  left_scale_r  <= cfg_wdata;
        CFG_RIGHT_PREC:  right_prec_r  <= cfg_wdata;
        CFG_RIGHT_SCALE: right_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // result type and operand routing: the smaller-scale side gets scaled
  always_comb begin
    left_smaller  = left_scale_r < right_scale_r;
    res_scale     = left_smaller ? right_scale_r : left_scale_r;
    left_int      = signed'({2'b00, left_prec_r}) - signed'({2'b00, left_scale_r});
    right_int     = signed'({2'b00, right_prec_r}) - signed'({2'b00, right_scale_r});
    res_int       = (left_int > right_int) ? left_int : right_int;
    res_prec_full = signed'({3'b000, res_scale}) + SUMP_W'(res_int) + SUMP_W'(1);

    entry_nxt.is_null = in_data.left_is_null | in_data.right_is_null;
    if (left_smaller) begin
      entry_nxt.scaled    = {in_data.left_word3, in_data.left_word2,
                             in_data.left_word1, in_data.left_word0};
      entry_nxt.addend    = {in_data.right_word3, in_data.right_word2,
                             in_data.right_word1, in_data.right_word0};
      entry_nxt.scale_exp = right_scale_r - left_scale_r;
    end else begin
      entry_nxt.scaled    = {in_data.right_word3, in_data.right_word2,
                             in_data.right_word1, in_data.right_word0};
      entry_nxt.addend    = {in_data.left_word3, in_data.left_word2,
                             in_data.left_word1, in_data.left_word0};
      entry_nxt.scale_exp = left_scale_r - right_scale_r;
    end

    // clamp precision into the table range
    if (res_prec_full < 0) begin
      entry_nxt.prec = '0;
    end else if (res_prec_full > SUMP_W'(MAX_RESULT_PREC)) begin
      entry_nxt.prec = PREC_W'(MAX_RESULT_PREC);
    end else begin
      entry_nxt.prec = res_prec_full[PREC_W-1:0];
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // power-of-five chain
  dsa_scaler u_scaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (entry_vld_r),
    .in_pipe  (entry_r),
    .out_vld  (scl_vld),
    .out_pipe (scl_pipe)
  );

  // power-of-two shift and overflow limit lookup
  always_ff @(posedge clk) begin
    sh_scaled_r <= scl_pipe.scaled << scl_pipe.scale_exp;
    sh_addend_r <= scl_pipe.addend;
    sh_limit_r  <= POW10[scl_pipe.prec];
    sh_null_r   <= scl_pipe.is_null;
  end

  // aligned add, wrapping at 256 bits
  always_ff @(posedge clk) begin
    add_sum_r   <= sh_scaled_r + sh_addend_r;
    add_limit_r <= sh_limit_r;
    add_null_r  <= sh_null_r;
  end

  // magnitude of the sum
  always_ff @(posedge clk) begin
    mag_sum_r   <= add_sum_r;
    mag_abs_r   <= add_sum_r[VAL_W-1] ? (~add_sum_r + VAL_W'(1)) : add_sum_r;
    mag_limit_r <= add_limit_r;
    mag_null_r  <= add_null_r;
  end

  // overflow compare and null masking
  always_comb begin
    over = mag_abs_r[VAL_W-1] | (mag_abs_r >= mag_limit_r);
    if (mag_null_r) begin
      out_nxt             = '0;
      out_nxt.sum_is_null = 1'b1;
    end else begin
      out_nxt.sum_word0   = mag_sum_r[WORD_W-1:0];
      out_nxt.sum_word1   = mag_sum_r[2*WORD_W-1:WORD_W];
      out_nxt.sum_word2   = mag_sum_r[3*WORD_W-1:2*WORD_W];
      out_nxt.sum_word3   = mag_sum_r[4*WORD_W-1:3*WORD_W];
      out_nxt.sum_is_null = 1'b0;
      out_nxt.overflow    = over;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid bits for the stages outside the scaler
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
      sh_vld_r    <= 1'b0;
      add_vld_r   <= 1'b0;
      mag_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      entry_vld_r <= start & ~busy;
      sh_vld_r    <= scl_vld;
      add_vld_r   <= sh_vld_r;
      mag_vld_r   <= add_vld_r;
      out_vld_r   <= mag_vld_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scaled decimal adder. Rows are sent in bursts
// under a range of operand types; every accepted row is predicted at the
// transfer edge and each result strobe is compared against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dsa_pkg::*;

  typedef logic [VAL_W-1:0] wide_t;

  localparam wide_t ALL_ONES = {VAL_W{1'b1}};
  localparam wide_t MAX_POS  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam wide_t MIN_NEG  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int    RESULT_LATENCY = 68;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_data;
  logic               out_valid;
  out_item_t          out_data;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  // shadow copy of the operand type registers
  logic [CFG_W-1:0]   lprec_q;
  logic [CFG_W-1:0]   lscale_q;
  logic [CFG_W-1:0]   rprec_q;
  logic [CFG_W-1:0]   rscale_q;

  out_item_t          expected_sums[$];
  int                 mismatch_count;

  decimal_scaled_add_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // decimal arithmetic helpers
  // ---------------------------------------------------------------------------

  // multiply by ten n times, wrapping at the value width
  function automatic wide_t times_pow10(wide_t v, int n);
    for (int k = 0; k < n; k++) v = (v << 3) + (v << 1);
    return v;
  endfunction

  function automatic int aligned_scale();
    return (lscale_q > rscale_q) ? int'(lscale_q) : int'(rscale_q);
  endfunction

  // derived result precision, capped
  function automatic int result_digits();
    int lint;
    int rint;
    int digits;
    lint = int'(lprec_q) - int'(lscale_q);
    rint = int'(rprec_q) - int'(rscale_q);
    digits = aligned_scale() + ((lint > rint) ? lint : rint) + 1;
    if (digits > MAX_RESULT_PREC) digits = MAX_RESULT_PREC;
    if (digits < 0) digits = 0;
    return digits;
  endfunction

  // expected result of one row under the current operand types
  function automatic out_item_t predict_sum(in_item_t row);
    out_item_t res;
    wide_t     lv;
    wide_t     rv;
    wide_t     total;
    wide_t     mag;
    wide_t     bound;
    res = '0;
    if (row.left_is_null || row.right_is_null) begin
      res.sum_is_null = 1'b1;
      return res;
    end
    lv = {row.left_word3, row.left_word2, row.left_word1, row.left_word0};
    rv = {row.right_word3, row.right_word2, row.right_word1, row.right_word0};
    lv = times_pow10(lv, aligned_scale() - int'(lscale_q));
    rv = times_pow10(rv, aligned_scale() - int'(rscale_q));
    total = lv + rv;
    mag = total[VAL_W-1] ? (~total + wide_t'(1)) : total;
    bound = times_pow10(wide_t'(1), result_digits());
    // the most negative value keeps its sign bit and always overflows
    res.overflow = mag[VAL_W-1] ? 1'b1 : (mag >= bound);
    {res.sum_word3, res.sum_word2, res.sum_word1, res.sum_word0} = total;
    return res;
  endfunction

  function automatic in_item_t make_row(wide_t lv, logic lnull, wide_t rv, logic rnull);
    in_item_t row;
    {row.left_word3, row.left_word2, row.left_word1, row.left_word0}     = lv;
    {row.right_word3, row.right_word2, row.right_word1, row.right_word0} = rv;
    row.left_is_null  = lnull;
    row.right_is_null = rnull;
    return row;
  endfunction

  // operand drawn from a mix of shapes; shift is its scale alignment
  function automatic wide_t random_operand(int shift);
    wide_t       v;
    logic [127:0] half;
    int          tiny;
    int          k;
    int          delta;
    case ($urandom_range(0, 9))
      0, 1, 2: v = {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
      3, 4: begin
        half = {$urandom, $urandom, $urandom, $urandom};
        v = {{128{half[127]}}, half};
      end
      5: begin
        tiny = $urandom;
        v = wide_t'(tiny);
      end
      6, 7, 8: begin
        // close to the overflow bound once aligned
        k = result_digits() - shift + int'($urandom_range(0, 2)) - 1;
        if (k < 0) k = 0;
        delta = int'($urandom_range(0, 4)) - 2;
        v = times_pow10(wide_t'(1), k) + wide_t'(delta);
        if ($urandom_range(0, 1)) v = ~v + wide_t'(1);
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = ALL_ONES;
          2:       v = MAX_POS;
          3:       v = MIN_NEG;
          default: v = wide_t'(1);
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t random_row();
    return make_row(random_operand(aligned_scale() - int'(lscale_q)),
                    ($urandom_range(0, 11) == 0),
                    random_operand(aligned_scale() - int'(rscale_q)),
                    ($urandom_range(0, 11) == 0));
  endfunction

  // ---------------------------------------------------------------------------
  // transfer monitor: shadow registers and predictions
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      lprec_q  <= LEFT_PREC_RST;
      lscale_q <= LEFT_SCALE_RST;
      rprec_q  <= RIGHT_PREC_RST;
      rscale_q <= RIGHT_SCALE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEFT_PREC:   lprec_q  <= cfg_wdata;
          CFG_LEFT_SCALE:  lscale_q <= cfg_wdata;
          CFG_RIGHT_PREC:  rprec_q  <= cfg_wdata;
          CFG_RIGHT_SCALE: rscale_q <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) expected_sums.insert(expected_sums.size(), predict_sum(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %0s mismatch, expected %h got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_sums.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected: %h", $realtime, out_data);
      end else begin
        exp_r = expected_sums.pop_front();
        check_field("sum_word0", exp_r.sum_word0, out_data.sum_word0);
        check_field("sum_word1", exp_r.sum_word1, out_data.sum_word1);
        check_field("sum_word2", exp_r.sum_word2, out_data.sum_word2);
        check_field("sum_word3", exp_r.sum_word3, out_data.sum_word3);
        check_field("sum_is_null", WORD_W'(exp_r.sum_is_null), WORD_W'(out_data.sum_is_null));
        check_field("overflow", WORD_W'(exp_r.overflow), WORD_W'(out_data.overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus primitives
  // ---------------------------------------------------------------------------

  // hold the row until it transfers
  task automatic send_row(in_item_t row);
    start   <= 1'b1;
    in_data <= row;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // pause until every predicted result has come back; the first edge lets
  // the last transfer's prediction reach the queue
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_types(int lp, int ls, int rp, int rs);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LEFT_PREC;
    cfg_wdata <= CFG_W'(lp);
    @(posedge clk);
    cfg_index <= CFG_LEFT_SCALE;
    cfg_wdata <= CFG_W'(ls);
    @(posedge clk);
    cfg_index <= CFG_RIGHT_PREC;
    cfg_wdata <= CFG_W'(rp);
    @(posedge clk);
    cfg_index <= CFG_RIGHT_SCALE;
    cfg_wdata <= CFG_W'(rs);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset types give 39 result digits at scale 0
  task automatic test_reset_types();
    wide_t lim;
    lim = times_pow10(wide_t'(1), 39);
    send_row(make_row('0, 1'b0, '0, 1'b0));
    send_row(make_row(lim - 1, 1'b0, '0, 1'b0));
    send_row(make_row(lim - 1, 1'b0, wide_t'(1), 1'b0));
    send_row(make_row(~(lim - 1) + 1, 1'b0, '0, 1'b0));
    send_row(make_row(~(lim - 1) + 1, 1'b0, ALL_ONES, 1'b0));
    send_row(make_row(MAX_POS, 1'b0, wide_t'(1), 1'b0));
    send_row(make_row(MIN_NEG, 1'b0, '0, 1'b0));
    send_row(make_row(ALL_ONES, 1'b0, ALL_ONES, 1'b0));
    send_row(make_row(ALL_ONES, 1'b1, wide_t'(5), 1'b0));
    send_row(make_row(wide_t'(5), 1'b0, ALL_ONES, 1'b1));
    send_row(make_row(ALL_ONES, 1'b1, ALL_ONES, 1'b1));
    send_row(make_row({64{4'hA}}, 1'b0, {64{4'h5}}, 1'b0));
  endtask

  // unequal scales: the operand with fewer fractional digits is scaled up
  task automatic test_scale_alignment();
    wide_t p11;
    p11 = times_pow10(wide_t'(1), 11);
    write_types(10, 2, 12, 5);
    send_row(make_row(wide_t'(1), 1'b0, wide_t'(1), 1'b0));
    send_row(make_row(p11 - 1, 1'b0, wide_t'(999), 1'b0));
    send_row(make_row(p11 - 1, 1'b0, wide_t'(1000), 1'b0));
    write_types(12, 5, 10, 2);
    send_row(make_row(~wide_t'(999) + 1, 1'b0, ~(p11 - 1) + 1, 1'b0));
    send_row(make_row(~wide_t'(1000) + 1, 1'b0, ~(p11 - 1) + 1, 1'b0));
  endtask

  // register extremes: one digit, capped precision, scale gaps past 76
  task automatic test_register_extremes();
    wide_t p65;
    p65 = times_pow10(wide_t'(1), 65);
    write_types(0, 0, 0, 0);
    send_row(make_row(wide_t'(9), 1'b0, '0, 1'b0));
    send_row(make_row(wide_t'(9), 1'b0, wide_t'(1), 1'b0));
    send_row(make_row(~wide_t'(10) + 1, 1'b0, '0, 1'b0));
    write_types(127, 0, 127, 127);
    send_row(make_row(wide_t'(1), 1'b0, '0, 1'b0));
    send_row(make_row(random_operand(127), 1'b0, random_operand(0), 1'b0));
    write_types(76, 76, 76, 76);
    send_row(make_row(p65 - 1, 1'b0, '0, 1'b0));
    send_row(make_row(p65, 1'b0, '0, 1'b0));
    write_types(1, 0, 76, 76);
    send_row(make_row(wide_t'(9), 1'b0, '0, 1'b0));
  endtask

  // random rows over a series of operand types, sent in bursts
  task automatic test_random_rows();
    int per_phase;
    int burst_left;
    int lp;
    int ls;
    int rp;
    int rs;
    per_phase = 96;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       begin lp = 38;  ls = 0;   rp = 38; rs = 0;  end
        1:       begin lp = 18;  ls = 4;   rp = 20; rs = 9;  end
        2:       begin lp = 76;  ls = 76;  rp = 76; rs = 76; end
        3:       begin lp = 1;   ls = 0;   rp = 1;  rs = 0;  end
        4:       begin lp = 76;  ls = 0;   rp = 76; rs = 76; end
        5:       begin lp = 38;  ls = 10;  rp = 20; rs = 3;  end
        6:       begin lp = 127; ls = 127; rp = 0;  rs = 0;  end
        7:       begin lp = 65;  ls = 30;  rp = 40; rs = 0;  end
        default: begin
          lp = $urandom_range(1, 76);
          ls = $urandom_range(0, lp);
          rp = $urandom_range(1, 76);
          rs = $urandom_range(0, rp);
        end
      endcase
      write_types(lp, ls, rp, rs);
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < per_phase; n++) begin
        // let the pipeline empty completely now and then
        if (n == per_phase / 2 && phase % 3 == 0) wait_idle();
        send_row(random_row());
        burst_left--;
        if (burst_left == 0) begin
          if (phase != 1 && $urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
          burst_left = $urandom_range(1, 40);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_LEFT_PREC;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_types();
    test_scale_alignment();
    test_register_extremes();
    test_random_rows();

    wait_idle();
    repeat (RESULT_LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
